/* src/jsu_pkg.sv */
package jsu_pkg;

  localparam int PEND_DEPTH = 12;
  localparam int CNT_W      = 4;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [7:0] BS_CODE  = 8'h08;
  localparam logic [7:0] FF_CODE  = 8'h0C;
  localparam logic [7:0] LF_CODE  = 8'h0A;
  localparam logic [7:0] CR_CODE  = 8'h0D;
  localparam logic [7:0] TAB_CODE = 8'h09;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PARSE,
    S_EMIT,
    S_FLUSH
  } state_t;

  // bytes dropped from the head of the pending buffer after a decision
  typedef enum logic [1:0] {
    CONS_1,
    CONS_2,
    CONS_6,
    CONS_12
  } cons_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic emit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic dec_done;
    logic hold_valid;
    logic can_push;
    logic seq_last;
  } sts_t;

  // {valid, value}
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  // {valid, 16-bit value}
  function automatic logic [16:0] hex_quad(input logic [7:0] c3, input logic [7:0] c2,
                                           input logic [7:0] c1, input logic [7:0] c0);
    logic [4:0] n3, n2, n1, n0;
    n3 = hex_nib(c3);
    n2 = hex_nib(c2);
    n1 = hex_nib(c1);
    n0 = hex_nib(c0);
    return {n3[4] & n2[4] & n1[4] & n0[4], n3[3:0], n2[3:0], n1[3:0], n0[3:0]};
  endfunction

endpackage

/* src/jsu_ctrl.sv */
module jsu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  jsu_pkg::sts_t sts,
  output jsu_pkg::cmd_t cmd
);

  jsu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jsu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jsu_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = jsu_pkg::S_PARSE;
      end
      jsu_pkg::S_PARSE: begin
        state_nxt = sts.dec_done ? jsu_pkg::S_FLUSH : jsu_pkg::S_EMIT;
      end
      jsu_pkg::S_EMIT: begin
        if ((!sts.hold_valid || sts.can_push) && sts.seq_last) state_nxt = jsu_pkg::S_PARSE;
      end
      jsu_pkg::S_FLUSH: begin
        if (!sts.hold_valid || sts.can_push) state_nxt = jsu_pkg::S_IDLE;
      end
      default: state_nxt = jsu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      jsu_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      jsu_pkg::S_PARSE: begin
        cmd.decide = !sts.dec_done;
      end
      jsu_pkg::S_EMIT: begin
        cmd.emit = !sts.hold_valid || sts.can_push;
      end
      jsu_pkg::S_FLUSH: begin
        cmd.flush = sts.hold_valid && sts.can_push;
      end
      default: ;
    endcase
  end

endmodule

/* src/jsu_datapath.sv */
module jsu_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic          out_tuser,
  input  jsu_pkg::cmd_t cmd,
  output jsu_pkg::sts_t sts
);

  localparam int D = jsu_pkg::PEND_DEPTH;
  localparam int W = jsu_pkg::CNT_W;

  logic [7:0]   buf_r [D];
  logic [7:0]   buf_nxt [D];
  logic [W-1:0] cnt_r, cnt_nxt;
  logic         fin_r;

  logic [7:0]   seq_r [4];
  logic [1:0]   len_r;
  logic [1:0]   idx_r;
  logic [7:0]   hold_r;
  logic         hold_vld_r;

  logic         out_vld_r;
  logic [7:0]   out_byte_r;
  logic         out_last_r;
  logic         out_end_r;

  // decoder on the head of the pending buffer
  logic          dec_done;
  logic [7:0]    dec_seq [4];
  logic [1:0]    dec_len;
  jsu_pkg::cons_t dec_cons;
  logic          fail;
  logic [16:0]   hq1, hq2;
  logic [15:0]   cp1, cp2;
  logic [20:0]   full;
  logic          pair_ok;

  assign hq1 = jsu_pkg::hex_quad(buf_r[2], buf_r[3], buf_r[4], buf_r[5]);
  assign hq2 = jsu_pkg::hex_quad(buf_r[8], buf_r[9], buf_r[10], buf_r[11]);
  assign cp1 = hq1[15:0];
  assign cp2 = hq2[15:0];
  assign full = jsu_pkg::SUPP_BASE + {1'b0, cp1[9:0], cp2[9:0]};
  assign pair_ok = (buf_r[6] == jsu_pkg::CH_BSL) && (buf_r[7] == jsu_pkg::CH_U) && hq2[16]
                   && (cp2[15:10] == jsu_pkg::LO_SURR_TAG);

  always_comb begin
    dec_done = 1'b0;
    dec_seq  = '{default: 8'h00};
    dec_len  = 2'd0;
    dec_cons = jsu_pkg::CONS_1;
    fail     = 1'b0;
    if (cnt_r == '0) begin
      dec_done = 1'b1;
    end else if (buf_r[0] != jsu_pkg::CH_BSL) begin
      dec_seq[0] = buf_r[0];
    end else if (cnt_r < W'(2)) begin
      // lone backslash: goes out literally only at end of string
      if (fin_r) dec_seq[0] = jsu_pkg::CH_BSL;
      else dec_done = 1'b1;
    end else begin
      dec_cons = jsu_pkg::CONS_2;
      case (buf_r[1])
        jsu_pkg::CH_QUOTE: dec_seq[0] = jsu_pkg::CH_QUOTE;
        jsu_pkg::CH_BSL:   dec_seq[0] = jsu_pkg::CH_BSL;
        jsu_pkg::CH_SLASH: dec_seq[0] = jsu_pkg::CH_SLASH;
        jsu_pkg::CH_B:     dec_seq[0] = jsu_pkg::BS_CODE;
        jsu_pkg::CH_F:     dec_seq[0] = jsu_pkg::FF_CODE;
        jsu_pkg::CH_N:     dec_seq[0] = jsu_pkg::LF_CODE;
        jsu_pkg::CH_R:     dec_seq[0] = jsu_pkg::CR_CODE;
        jsu_pkg::CH_T:     dec_seq[0] = jsu_pkg::TAB_CODE;
        jsu_pkg::CH_U: begin
          if (cnt_r < W'(6)) begin
            if (fin_r) fail = 1'b1;
            else dec_done = 1'b1;
          end else if (!hq1[16]) begin
            fail = 1'b1;
          end else if (cp1[15:10] == jsu_pkg::HI_SURR_TAG) begin
            if (cnt_r < W'(D)) begin
              if (fin_r) fail = 1'b1;
              else dec_done = 1'b1;
            end else if (pair_ok) begin
              dec_seq[0] = {5'b11110, full[20:18]};
              dec_seq[1] = {2'b10, full[17:12]};
              dec_seq[2] = {2'b10, full[11:6]};
              dec_seq[3] = {2'b10, full[5:0]};
              dec_len    = 2'd3;
              dec_cons   = jsu_pkg::CONS_12;
            end else begin
              fail = 1'b1;
            end
          end else begin
            dec_cons = jsu_pkg::CONS_6;
            if (cp1 < 16'h0080) begin
              dec_seq[0] = cp1[7:0];
            end else if (cp1 < 16'h0800) begin
              dec_seq[0] = {3'b110, cp1[10:6]};
              dec_seq[1] = {2'b10, cp1[5:0]};
              dec_len    = 2'd1;
            end else begin
              dec_seq[0] = {4'b1110, cp1[15:12]};
              dec_seq[1] = {2'b10, cp1[11:6]};
              dec_seq[2] = {2'b10, cp1[5:0]};
              dec_len    = 2'd2;
            end
          end
        end
        default: begin
          dec_seq[0] = jsu_pkg::CH_BSL;
          dec_seq[1] = buf_r[1];
          dec_len    = 2'd1;
        end
      endcase
      // failed escape: backslash goes out alone, rest is reparsed
      if (fail) begin
        dec_seq  = '{default: 8'h00};
        dec_seq[0] = jsu_pkg::CH_BSL;
        dec_len  = 2'd0;
        dec_cons = jsu_pkg::CONS_1;
      end
    end
  end

  // pending buffer: append at the tail, drop from the head
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      buf_nxt[cnt_r] = in_tdata;
      cnt_nxt = cnt_r + W'(1);
    end else if (cmd.decide) begin
      for (int i = 0; i < D; i++) begin
        case (dec_cons)
          jsu_pkg::CONS_1: if (i + 1 < D) buf_nxt[i] = buf_r[i + 1];
          jsu_pkg::CONS_2: if (i + 2 < D) buf_nxt[i] = buf_r[i + 2];
          jsu_pkg::CONS_6: if (i + 6 < D) buf_nxt[i] = buf_r[i + 6];
          default: ;
        endcase
      end
      case (dec_cons)
        jsu_pkg::CONS_1: cnt_nxt = cnt_r - W'(1);
        jsu_pkg::CONS_2: cnt_nxt = cnt_r - W'(2);
        jsu_pkg::CONS_6: cnt_nxt = cnt_r - W'(6);
        default:         cnt_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (cmd.load) fin_r <= in_tlast;
    if (cmd.decide) begin
      seq_r <= dec_seq;
      len_r <= dec_len;
    end
    if (cmd.emit) hold_r <= seq_r[idx_r];
    // output register only loads when the held byte actually moves out
    if ((cmd.emit && hold_vld_r) || cmd.flush) begin
      out_byte_r <= hold_r;
      out_last_r <= cmd.flush;
      out_end_r  <= cmd.flush && fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      idx_r      <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.decide) idx_r <= '0;
      else if (cmd.emit) idx_r <= idx_r + 2'd1;
      if (cmd.emit) hold_vld_r <= 1'b1;
      else if (cmd.flush) hold_vld_r <= 1'b0;
      // held byte moves out only once the next one (or end of run) is known
      if ((cmd.emit && hold_vld_r) || cmd.flush) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  assign sts.dec_done   = dec_done;
  assign sts.hold_valid = hold_vld_r;
  assign sts.can_push   = !out_vld_r || out_tready;
  assign sts.seq_last   = (idx_r == len_r);

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

endmodule

/* src/json_string_unescape_unit.sv */
// channel | direction | tdata           | tlast      | tuser
// in_     | slave     | [7:0] in_byte   | is_final   | -
// out_    | master    | [7:0] out_byte  | run_last   | string_end
//
// An input byte is taken while idle, then the head of the pending buffer is
// decided and each resulting output byte is emitted, and the run is closed by
// an empty decision and a flush. Replays after a failed escape decide the
// reparsed bytes again.
// Synchronous reset empties the pending buffer and the output stage.
// A stalled out_tready holds the sequencer; in_tready is high only when idle.
module json_string_unescape_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] string_end
);

  jsu_pkg::cmd_t cmd;
  jsu_pkg::sts_t sts;

  jsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  jsu_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

/* test/json_unescape_checker.sv */
module json_unescape_checker
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic       out_tlast,
  input  logic       out_tuser,  // [0] string_end
  output int         mismatches,
  output int         outstanding,
  output int         bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } utf8_beat_t;

  utf8_beat_t utf8_due[$];
  logic [7:0] held[PEND_DEPTH];  // bytes of an escape not yet decided
  int         held_cnt;
  logic [7:0] step_out[$];
  int         miss_cnt;
  int         seen_cnt;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41 + 8'd10);
    return -1;
  endfunction

  // value of four hex digits starting at held[at], -1 if any is not hex
  function automatic int quad_at(input int at);
    int acc;
    int d;
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      d = hex_val(held[at + i]);
      if (d < 0) return -1;
      acc = acc * 16 + d;
    end
    return acc;
  endfunction

  task automatic put(input logic [7:0] v);
    if (step_out.size() < PEND_DEPTH) step_out.push_back(v);
  endtask

  task automatic unescape_byte(input logic [7:0] b, input logic fin);
    int          n;
    int          pos;
    int          avail;
    int          q1;
    int          q2;
    bit          done;
    bit          fail;
    bit          stall;
    logic [7:0]  esc;
    logic [15:0] cp;
    logic [15:0] cp2;
    logic [20:0] full;
    utf8_beat_t  beat;
    step_out.delete();
    if (held_cnt >= PEND_DEPTH) held_cnt = 0;
    held[held_cnt] = b;
    n = held_cnt + 1;
    pos = 0;
    done = 1'b0;
    while (pos < n && !done) begin
      avail = n - pos;
      fail = 1'b0;
      stall = 1'b0;
      if (held[pos] != CH_BSL) begin
        put(held[pos]);
        pos++;
      end else if (avail < 2) begin
        if (fin) begin
          put(CH_BSL);
          pos++;
        end
        done = 1'b1;
      end else begin
        esc = held[pos + 1];
        case (esc)
          CH_QUOTE, CH_BSL, CH_SLASH: begin
            put(esc);
            pos += 2;
          end
          CH_B: begin put(BS_CODE);  pos += 2; end
          CH_F: begin put(FF_CODE);  pos += 2; end
          CH_N: begin put(LF_CODE);  pos += 2; end
          CH_R: begin put(CR_CODE);  pos += 2; end
          CH_T: begin put(TAB_CODE); pos += 2; end
          CH_U: begin
            q1 = (avail >= 6) ? quad_at(pos + 2) : -1;
            cp = q1[15:0];
            if (avail < 6) begin
              fail = fin;
              stall = !fin;
            end else if (q1 < 0) begin
              fail = 1'b1;
            end else if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
              if (avail < 12) begin
                fail = fin;
                stall = !fin;
              end else begin
                q2 = (held[pos + 6] == CH_BSL && held[pos + 7] == CH_U) ? quad_at(pos + 8) : -1;
                cp2 = q2[15:0];
                if (q2 >= 0 && cp2 >= 16'hDC00 && cp2 <= 16'hDFFF) begin
                  full = 21'h10000 + {1'b0, cp[9:0], cp2[9:0]};
                  put(LEAD4 | full[20:18]);
                  put(CONT | full[17:12]);
                  put(CONT | full[11:6]);
                  put(CONT | full[5:0]);
                  pos += 12;
                end else begin
                  fail = 1'b1;
                end
              end
            end else begin
              if (cp < 16'h80) begin
                put(cp[7:0]);
              end else if (cp < 16'h800) begin
                put(LEAD2 | cp[10:6]);
                put(CONT | cp[5:0]);
              end else begin
                put(LEAD3 | cp[15:12]);
                put(CONT | cp[11:6]);
                put(CONT | cp[5:0]);
              end
              pos += 6;
            end
          end
          default: begin
            put(CH_BSL);
            put(esc);
            pos += 2;
          end
        endcase
        if (stall) begin
          done = 1'b1;
        end else if (fail) begin
          // drop only the backslash, the rest is parsed again
          put(CH_BSL);
          pos++;
        end
      end
    end
    if (pos > n) pos = n;
    for (int i = 0; i < n - pos; i++) held[i] = held[pos + i];
    held_cnt = fin ? 0 : n - pos;
    for (int j = 0; j < step_out.size(); j++) begin
      beat.data = step_out[j];
      beat.run_last = (j == step_out.size() - 1);
      beat.string_end = beat.run_last && fin;
      utf8_due.push_back(beat);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    miss_cnt++;
  endtask

  initial begin
    held_cnt = 0;
    miss_cnt = 0;
    seen_cnt = 0;
  end

  always @(posedge clk) begin
    utf8_beat_t want;
    if (!rst_n) begin
      held_cnt = 0;
      utf8_due.delete();
    end else begin
      if (in_tvalid && in_tready) unescape_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (utf8_due.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h", out_tdata));
        end else begin
          want = utf8_due.pop_front();
          seen_cnt++;
          if (out_tdata !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_tdata, want.data));
          if (out_tlast !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b (byte %02h)",
                                      out_tlast, want.run_last, want.data));
          if (out_tuser !== want.string_end)
            report_mismatch($sformatf("string_end %b, want %b (byte %02h)",
                                      out_tuser, want.string_end, want.data));
        end
      end
    end
    mismatches <= miss_cnt;
    outstanding <= utf8_due.size();
    bytes_checked <= seen_cnt;
  end

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 100;
  localparam int ITEM_TARGET    = 360;

  typedef enum int {
    TK_PLAIN,
    TK_RAW,
    TK_SHORT,
    TK_OTHER,
    TK_UCODE,
    TK_PAIR,
    TK_LONE_HI,
    TK_LONE_LO,
    TK_BAD_HEX
  } token_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  int mismatches;
  int outstanding;
  int bytes_checked;

  logic [7:0]  text_q[$];
  int          strings_sent = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          hold_req = 0;

  logic [7:0]  short_codes[8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH,
                                  jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                                  jsu_pkg::CH_R, jsu_pkg::CH_T};
  // characters just outside the hex ranges, plus a few strtol would accept
  logic [7:0]  not_hex[10] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67,
                               8'h20, 8'h2B, 8'h2D, 8'h78};
  logic [15:0] cp_edges[10] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
                                16'hD7FF, 16'hDC00, 16'hDFFF, 16'hE000, 16'hFFFF};

  json_string_unescape_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  json_unescape_checker i_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .bytes_checked(bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [15:0] rand_bmp();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom_range(16'h7F));
      1: v = 16'($urandom_range(16'h7FF, 16'h80));
      2: v = cp_edges[$urandom_range(9)];
      default: begin
        v = 16'($urandom_range(16'hFFFF, 16'h800));
        if (v >= 16'hD800 && v <= 16'hDBFF) v = v ^ 16'h2000;
      end
    endcase
    return v;
  endfunction

  function automatic token_t pick_token();
    int r;
    r = $urandom_range(99);
    if (r < 28) return TK_PLAIN;
    if (r < 36) return TK_RAW;
    if (r < 52) return TK_SHORT;
    if (r < 58) return TK_OTHER;
    if (r < 72) return TK_UCODE;
    if (r < 84) return TK_PAIR;
    if (r < 90) return TK_LONE_HI;
    if (r < 94) return TK_LONE_LO;
    return TK_BAD_HEX;
  endfunction

  task automatic push_u(input logic [15:0] cp);
    text_q.push_back(jsu_pkg::CH_BSL);
    text_q.push_back(jsu_pkg::CH_U);
    text_q.push_back(hex_char(cp[15:12]));
    text_q.push_back(hex_char(cp[11:8]));
    text_q.push_back(hex_char(cp[7:4]));
    text_q.push_back(hex_char(cp[3:0]));
  endtask

  task automatic add_token(input token_t kind);
    logic [7:0] c;
    int         k;
    case (kind)
      TK_PLAIN: begin
        c = 8'($urandom_range(8'h7E, 8'h20));
        text_q.push_back((c == jsu_pkg::CH_BSL) ? 8'h5B : c);
      end
      TK_RAW: text_q.push_back(8'($urandom_range(255)));
      TK_SHORT: begin
        text_q.push_back(jsu_pkg::CH_BSL);
        text_q.push_back(short_codes[$urandom_range(7)]);
      end
      TK_OTHER: begin
        c = 8'($urandom_range(255));
        text_q.push_back(jsu_pkg::CH_BSL);
        text_q.push_back((c == jsu_pkg::CH_U) ? 8'h78 : c);
      end
      TK_UCODE: push_u(rand_bmp());
      TK_PAIR: begin
        push_u(16'(16'hD800 + $urandom_range(16'h3FF)));
        push_u(16'(16'hDC00 + $urandom_range(16'h3FF)));
      end
      TK_LONE_HI: begin
        push_u(16'(16'hD800 + $urandom_range(16'h3FF)));
        case ($urandom_range(3))
          0: push_u(rand_bmp());
          1: push_u(16'(16'hD800 + $urandom_range(16'h3FF)));
          2: add_token(TK_SHORT);
          default: add_token(TK_PLAIN);
        endcase
      end
      TK_LONE_LO: push_u(16'(16'hDC00 + $urandom_range(16'h3FF)));
      default: begin
        // sometimes the broken quad is the second half of a pair
        if ($urandom_range(2) == 0) push_u(16'(16'hD800 + $urandom_range(16'h3FF)));
        k = $urandom_range(3);
        text_q.push_back(jsu_pkg::CH_BSL);
        text_q.push_back(jsu_pkg::CH_U);
        for (int i = 0; i < 4; i++)
          text_q.push_back((i == k) ? not_hex[$urandom_range(9)]
                                    : hex_char(4'($urandom_range(15))));
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(10, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(16, 1);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    strings_sent++;
    text_q.delete();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // output side: changing stall patterns, plus a long hold-off on request
  initial begin
    int rx_mode;
    int rx_left;
    int rx_tick;
    int hold_served;
    rx_mode = 0;
    rx_left = 0;
    rx_tick = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_served) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served++;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(3);
          rx_left = $urandom_range(200, 30);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(3) != 0);
          2: out_tready <= ($urandom_range(1) == 0);
          default: out_tready <= ((rx_tick % 7) < 3);
        endcase
      end
    end
  end

  // ends the run if no transfer happens for too long
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("json_string_unescape_unit test failed");
    $finish;
  end

  initial begin
    int si;
    int cut;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings: byte extremes, \u0000, other escape, lone and
    // truncated backslash, lone low and truncated high surrogate, \n
    text_q = '{8'h00, 8'hFF};
    send_text();
    push_u(16'h0000);
    send_text();
    text_q = '{jsu_pkg::CH_BSL, 8'h71};
    send_text();
    text_q = '{jsu_pkg::CH_BSL};
    send_text();
    push_u(16'hDC01);
    send_text();
    push_u(16'hD83D);
    send_text();
    text_q = '{jsu_pkg::CH_BSL, jsu_pkg::CH_N};
    send_text();
    wait_drained();

    si = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (si == 5) hold_req <= hold_req + 1;
      gaps_on = (si >= 5 && si < 9) ? 1'b0 : ($urandom_range(3) != 0);
      if (si == 16) wait_drained();
      for (int t = $urandom_range(5, 1); t > 0; t--) add_token(pick_token());
      // some strings lose up to five trailing bytes, which can cut an escape short
      if (text_q.size() > 1 && $urandom_range(7) == 0) begin
        cut = $urandom_range((text_q.size() - 1 < 5) ? text_q.size() - 1 : 5, 1);
        repeat (cut) void'(text_q.pop_back());
      end
      send_text();
      si++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d strings, %0d input bytes with bursty input and a %0d-cycle output hold-off",
             strings_sent, bytes_sent, LONG_HOLD);
    $display("%0d output bytes checked, %0d mismatches", bytes_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("json_string_unescape_unit test passed");
    end else begin
      $display("json_string_unescape_unit test failed");
    end
    $finish;
  end

endmodule
